// ===== rtl/trz_pkg.sv =====
// ----------------------------------------------------------------------------
// trz_pkg
// Shared constants, opcodes and sequencer states of the triangle rasterizer.
// ----------------------------------------------------------------------------
package trz_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 64;
    localparam int DEPTH_BITS    = 16;

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = $clog2(SCREEN_HEIGHT);
    localparam int AW     = $clog2(PIXELS);

    localparam int CW     = 12;   // screen coordinate width
    localparam int ZW     = 16;   // vertex depth width
    localparam int COLW   = 24;   // color width
    localparam int CNTW   = 13;   // written count width
    localparam int EW     = 13;   // edge vector width
    localparam int WW     = 30;   // edge weight width
    localparam int PRW    = 48;   // product / accumulator width
    localparam int DVW    = 27;   // divisor (absolute area) width
    localparam int QW     = 49;   // dividend / quotient width

    localparam logic [CNTW-1:0] COUNT_MAX = '1;

    localparam logic [DEPTH_BITS-1:0] DEPTH_LOW = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_HIGH = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic [QW-1:0] DEPTH_MAG_NEG = QW'(64'd1 << (DEPTH_BITS - 1));
    localparam logic [QW-1:0] DEPTH_MAG_POS = DEPTH_MAG_NEG - QW'(1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RADDR,
        ST_RDATA,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_BOX,
        ST_BOX2,
        ST_PD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_PW,
        ST_PT,
        ST_N0,
        ST_N1,
        ST_N2,
        ST_N3,
        ST_DIVS,
        ST_DIVW,
        ST_SAT,
        ST_PRD,
        ST_PCMP,
        ST_PNEXT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/trz_in_if.sv =====
// ----------------------------------------------------------------------------
// trz_in_if
// Request channel of the rasterizer: opcode, three vertices and a color.
// ----------------------------------------------------------------------------
interface trz_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [11:0]       ax;
    logic signed [11:0]       ay;
    logic signed [15:0]       az;
    logic signed [11:0]       bx;
    logic signed [11:0]       by;
    logic signed [15:0]       bz;
    logic signed [11:0]       cx;
    logic signed [11:0]       cy;
    logic signed [15:0]       cz;
    logic [23:0]              fill_color;

    modport source (output valid, opcode, ax, ay, az, bx, by, bz, cx, cy, cz, fill_color,
                    input ready);
    modport sink (input valid, opcode, ax, ay, az, bx, by, bz, cx, cy, cz, fill_color,
                  output ready);
endinterface

// ===== rtl/trz_out_if.sv =====
// ----------------------------------------------------------------------------
// trz_out_if
// Result channel of the rasterizer: pixel color, pixel depth, written count.
// ----------------------------------------------------------------------------
interface trz_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        pixel_color;
    logic signed [15:0] pixel_depth;
    logic [12:0]        written_count;

    modport source (output valid, pixel_color, pixel_depth, written_count, input ready);
    modport sink (input valid, pixel_color, pixel_depth, written_count, output ready);
endinterface

// ===== rtl/trz_ram.sv =====
// ----------------------------------------------------------------------------
// trz_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module trz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/trz_div.sv =====
// ----------------------------------------------------------------------------
// trz_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trz_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [trz_pkg::QW-1:0]    dividend,
    input  logic [trz_pkg::DVW-1:0]   divisor,
    output logic                      done,
    output logic [trz_pkg::QW-1:0]    quotient
);
    localparam int CTW = $clog2(trz_pkg::QW + 1);

    logic [trz_pkg::DVW-1:0] rem_reg;
    logic [trz_pkg::DVW-1:0] dsr_reg;
    logic [trz_pkg::QW-1:0]  quo_reg;
    logic [CTW-1:0]          cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [trz_pkg::DVW:0]   shifted;
    logic [trz_pkg::DVW:0]   diff;

    assign shifted = {rem_reg, quo_reg[trz_pkg::QW-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CTW'(trz_pkg::QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CTW'(1);
                if (cnt_reg == CTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not borrow
            if (!diff[trz_pkg::DVW])
            begin
                rem_reg <= diff[trz_pkg::DVW-1:0];
                quo_reg <= {quo_reg[trz_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[trz_pkg::DVW-1:0];
                quo_reg <= {quo_reg[trz_pkg::QW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/triangle_raster_zbuffer.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_zbuffer
// Barycentric triangle rasterizer with depth and color stores.
// ----------------------------------------------------------------------------
// One request is taken at a time and returns one result. Depth and color live in
// two synchronous RAMs of SCREEN_WIDTH*SCREEN_HEIGHT entries (4096 here). After
// reset the block sweeps both RAMs, one entry a cycle, before it takes its first
// request; a clear request does the same sweep and then reports. A read looks up
// one entry when on screen. A draw computes the area and the clamped bounding box,
// then walks the box pixel by pixel: every pixel takes the edge weights from the
// shared multiplier, and a covered pixel also runs the depth numerator, the depth
// divider and the RAM read-compare-write. Pixels are handled strictly one after
// another, so no two accesses to the same entry overlap. A result waits in an
// output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module triangle_raster_zbuffer (
    input  logic  clk,
    input  logic  rst_n,
    trz_in_if.sink    in_ch,
    trz_out_if.source out_ch
);
    localparam int XW = trz_pkg::XW;
    localparam int YW = trz_pkg::YW;
    localparam int AW = trz_pkg::AW;
    localparam int WW = trz_pkg::WW;
    localparam int PRW = trz_pkg::PRW;
    localparam int QW = trz_pkg::QW;
    localparam int DVW = trz_pkg::DVW;
    localparam int EW = trz_pkg::EW;
    localparam int DB = trz_pkg::DEPTH_BITS;
    localparam int CNTW = trz_pkg::CNTW;

    trz_pkg::state_t state_reg, state_next;

    // request fields
    trz_pkg::op_t           op_reg;
    logic signed [11:0]     ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [15:0]     az_reg, bz_reg, cz_reg;
    logic [23:0]            col_reg;
    logic signed [EW-1:0]   ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    logic                   onscr_reg;

    // setup and walk state
    logic                   sgn_reg;
    logic [DVW-1:0]         area_abs_reg;
    logic signed [11:0]     xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [XW-1:0]          x_reg;
    logic [YW-1:0]          y_reg;
    logic [AW-1:0]          row_reg;
    logic signed [EW-1:0]   dx_reg, dy_reg;
    logic signed [PRW-1:0]  prod_reg, acc_reg;
    logic signed [WW-1:0]   ux_reg, uy_reg, w0_reg, w1_reg, w2_reg;
    logic                   neg_reg;
    logic [QW-1:0]          dvd_reg;
    logic signed [DB-1:0]   dq_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [AW-1:0]          clr_reg;
    logic                   clr_report_reg;
    logic [23:0]            rcol_reg;
    logic signed [15:0]     rdep_reg;

    // result
    logic                   out_valid_reg;
    logic [23:0]            res_color_reg;
    logic signed [15:0]     res_depth_reg;
    logic [CNTW-1:0]        res_count_reg;

    // shared multiplier
    logic signed [WW-1:0]   mul_a;
    logic signed [15:0]     mul_b;
    logic signed [WW+15:0]  mul_p;

    // memories and divider
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [DB-1:0]          dep_wdata, dep_rdata;
    logic [23:0]            col_wdata, col_rdata;
    logic                   div_start, div_done;
    logic [QW-1:0]          div_q;

    logic                   in_fire;
    logic                   out_free;
    logic [AW-1:0]          pix_idx;
    logic signed [11:0]     mn_x, mn_y, mx_x, mx_y;
    logic signed [PRW-1:0]  num;
    logic [PRW-1:0]         num_mag;
    logic signed [WW-1:0]   w1_n, w2_n;
    logic signed [31:0]     rd_ext;

    function automatic logic num_area_neg(input logic signed [PRW-1:0] a,
                                          input logic signed [PRW-1:0] b);
        logic signed [PRW-1:0] d;
        d = a - b;
        return d[PRW-1];
    endfunction

    function automatic logic [DVW-1:0] area_mag(input logic signed [PRW-1:0] a,
                                                input logic signed [PRW-1:0] b);
        logic signed [PRW-1:0] d;
        d = a - b;
        return d[PRW-1] ? DVW'(-d) : DVW'(d);
    endfunction

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign pix_idx  = row_reg + AW'(x_reg);
    assign in_ch.ready = (state_reg == trz_pkg::ST_IDLE);

    trz_ram #(.WIDTH(DB), .DEPTH(trz_pkg::PIXELS)) u_depth_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (dep_wdata),
        .raddr (mem_raddr),
        .rdata (dep_rdata)
    );

    trz_ram #(.WIDTH(24), .DEPTH(trz_pkg::PIXELS)) u_color_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (col_wdata),
        .raddr (mem_raddr),
        .rdata (col_rdata)
    );

    trz_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (area_abs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trz_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (trz_pkg::op_t'(in_ch.opcode))
                        trz_pkg::OP_CLEAR: state_next = trz_pkg::ST_CLEAR;
                        trz_pkg::OP_DRAW:  state_next = trz_pkg::ST_A0;
                        trz_pkg::OP_READ:  state_next = trz_pkg::ST_RADDR;
                        default:           state_next = trz_pkg::ST_FINISH;
                    endcase
                end
            end
            trz_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(trz_pkg::PIXELS - 1))
                begin
                    state_next = clr_report_reg ? trz_pkg::ST_FINISH : trz_pkg::ST_IDLE;
                end
            end
            trz_pkg::ST_RADDR: state_next = onscr_reg ? trz_pkg::ST_RDATA : trz_pkg::ST_FINISH;
            trz_pkg::ST_RDATA: state_next = trz_pkg::ST_FINISH;
            trz_pkg::ST_A0:    state_next = trz_pkg::ST_A1;
            trz_pkg::ST_A1:    state_next = trz_pkg::ST_A2;
            trz_pkg::ST_A2:
            begin
                state_next = (acc_reg == prod_reg) ? trz_pkg::ST_FINISH : trz_pkg::ST_BOX;
            end
            trz_pkg::ST_BOX:   state_next = trz_pkg::ST_BOX2;
            trz_pkg::ST_BOX2:
            begin
                if (xlo_reg > xhi_reg || ylo_reg > yhi_reg)
                begin
                    state_next = trz_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = trz_pkg::ST_PD;
                end
            end
            trz_pkg::ST_PD:    state_next = trz_pkg::ST_M0;
            trz_pkg::ST_M0:    state_next = trz_pkg::ST_M1;
            trz_pkg::ST_M1:    state_next = trz_pkg::ST_M2;
            trz_pkg::ST_M2:    state_next = trz_pkg::ST_M3;
            trz_pkg::ST_M3:    state_next = trz_pkg::ST_M4;
            trz_pkg::ST_M4:    state_next = trz_pkg::ST_PW;
            trz_pkg::ST_PW:    state_next = trz_pkg::ST_PT;
            trz_pkg::ST_PT:
            begin
                if (w0_reg < 0 || w1_reg < 0 || w2_reg < 0)
                begin
                    state_next = trz_pkg::ST_PNEXT;
                end
                else
                begin
                    state_next = trz_pkg::ST_N0;
                end
            end
            trz_pkg::ST_N0:    state_next = trz_pkg::ST_N1;
            trz_pkg::ST_N1:    state_next = trz_pkg::ST_N2;
            trz_pkg::ST_N2:    state_next = trz_pkg::ST_N3;
            trz_pkg::ST_N3:    state_next = trz_pkg::ST_DIVS;
            trz_pkg::ST_DIVS:  state_next = trz_pkg::ST_DIVW;
            trz_pkg::ST_DIVW:  state_next = div_done ? trz_pkg::ST_SAT : trz_pkg::ST_DIVW;
            trz_pkg::ST_SAT:   state_next = trz_pkg::ST_PRD;
            trz_pkg::ST_PRD:   state_next = trz_pkg::ST_PCMP;
            trz_pkg::ST_PCMP:  state_next = trz_pkg::ST_PNEXT;
            trz_pkg::ST_PNEXT:
            begin
                if (AW'(x_reg) == AW'(xhi_reg) && AW'(y_reg) == AW'(yhi_reg))
                begin
                    state_next = trz_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = trz_pkg::ST_PD;
                end
            end
            trz_pkg::ST_FINISH: state_next = out_free ? trz_pkg::ST_IDLE : trz_pkg::ST_FINISH;
            default:            state_next = trz_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier operands, RAM ports, divider start
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = pix_idx;
        mem_raddr = pix_idx;
        dep_wdata = dq_reg;
        col_wdata = col_reg;
        div_start = 1'b0;
        case (state_reg)
            trz_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                dep_wdata = trz_pkg::DEPTH_LOW;
                col_wdata = '0;
            end
            trz_pkg::ST_RADDR:
            begin
                mem_raddr = AW'(ay_reg[YW-1:0]) * AW'(trz_pkg::SCREEN_WIDTH)
                          + AW'(ax_reg[XW-1:0]);
            end
            trz_pkg::ST_A0:
            begin
                mul_a = WW'(ex1_reg);
                mul_b = 16'(ey2_reg);
            end
            trz_pkg::ST_A1:
            begin
                mul_a = WW'(ex2_reg);
                mul_b = 16'(ey1_reg);
            end
            trz_pkg::ST_M0:
            begin
                mul_a = WW'(ex2_reg);
                mul_b = 16'(dy_reg);
            end
            trz_pkg::ST_M1:
            begin
                mul_a = WW'(dx_reg);
                mul_b = 16'(ey2_reg);
            end
            trz_pkg::ST_M2:
            begin
                mul_a = WW'(dx_reg);
                mul_b = 16'(ey1_reg);
            end
            trz_pkg::ST_M3:
            begin
                mul_a = WW'(ex1_reg);
                mul_b = 16'(dy_reg);
            end
            trz_pkg::ST_N0:
            begin
                mul_a = w0_reg;
                mul_b = az_reg;
            end
            trz_pkg::ST_N1:
            begin
                mul_a = w1_reg;
                mul_b = bz_reg;
            end
            trz_pkg::ST_N2:
            begin
                mul_a = w2_reg;
                mul_b = cz_reg;
            end
            trz_pkg::ST_DIVS: div_start = 1'b1;
            trz_pkg::ST_PCMP:
            begin
                // write only where the stored depth is strictly smaller
                mem_we = ($signed(dep_rdata) < dq_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // bounding box and per-pixel arithmetic helpers
    always_comb
    begin
        mn_x = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        mn_x = (mn_x < cx_reg) ? mn_x : cx_reg;
        mn_y = (ay_reg < by_reg) ? ay_reg : by_reg;
        mn_y = (mn_y < cy_reg) ? mn_y : cy_reg;
        mx_x = (ax_reg > bx_reg) ? ax_reg : bx_reg;
        mx_x = (mx_x > cx_reg) ? mx_x : cx_reg;
        mx_y = (ay_reg > by_reg) ? ay_reg : by_reg;
        mx_y = (mx_y > cy_reg) ? mx_y : cy_reg;
    end

    assign num     = acc_reg + prod_reg;
    assign num_mag = num[PRW-1] ? PRW'(0) - PRW'(num) : PRW'(num);
    assign w1_n    = sgn_reg ? -uy_reg : uy_reg;
    assign w2_n    = sgn_reg ? -ux_reg : ux_reg;
    assign rd_ext  = 32'(signed'(dep_rdata));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= trz_pkg::ST_CLEAR;
            clr_reg        <= '0;
            clr_report_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == trz_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(trz_pkg::PIXELS - 1))
                begin
                    clr_reg <= '0;
                end
            end
            if (in_fire)
            begin
                clr_report_reg <= 1'b1;
            end
            if (state_reg == trz_pkg::ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PRW'(mul_p);
        case (state_reg)
            trz_pkg::ST_IDLE:
            begin
                // capture the request and its edge vectors
                op_reg  <= trz_pkg::op_t'(in_ch.opcode);
                ax_reg  <= in_ch.ax;
                ay_reg  <= in_ch.ay;
                az_reg  <= in_ch.az;
                bx_reg  <= in_ch.bx;
                by_reg  <= in_ch.by;
                bz_reg  <= in_ch.bz;
                cx_reg  <= in_ch.cx;
                cy_reg  <= in_ch.cy;
                cz_reg  <= in_ch.cz;
                col_reg <= in_ch.fill_color;
                ex1_reg <= EW'(in_ch.cx) - EW'(in_ch.ax);
                ey1_reg <= EW'(in_ch.cy) - EW'(in_ch.ay);
                ex2_reg <= EW'(in_ch.bx) - EW'(in_ch.ax);
                ey2_reg <= EW'(in_ch.by) - EW'(in_ch.ay);
                onscr_reg <= (in_ch.ax >= 0)
                          && ($signed({in_ch.ax[11], in_ch.ax}) < 13'(trz_pkg::SCREEN_WIDTH))
                          && (in_ch.ay >= 0)
                          && ($signed({in_ch.ay[11], in_ch.ay}) < 13'(trz_pkg::SCREEN_HEIGHT));
                rcol_reg <= '0;
                rdep_reg <= '0;
                cnt_reg  <= '0;
            end
            trz_pkg::ST_RDATA:
            begin
                rcol_reg <= col_rdata;
                rdep_reg <= rd_ext[15:0];
            end
            trz_pkg::ST_A1: acc_reg <= prod_reg;
            trz_pkg::ST_A2:
            begin
                sgn_reg      <= num_area_neg(acc_reg, prod_reg);
                area_abs_reg <= area_mag(acc_reg, prod_reg);
            end
            trz_pkg::ST_BOX:
            begin
                // clamp the box to the screen on both ends
                xlo_reg <= (mn_x < 0) ? 12'sd0 : mn_x;
                ylo_reg <= (mn_y < 0) ? 12'sd0 : mn_y;
                xhi_reg <= (mx_x > 12'(trz_pkg::SCREEN_WIDTH - 1))
                         ? 12'(trz_pkg::SCREEN_WIDTH - 1) : mx_x;
                yhi_reg <= (mx_y > 12'(trz_pkg::SCREEN_HEIGHT - 1))
                         ? 12'(trz_pkg::SCREEN_HEIGHT - 1) : mx_y;
            end
            trz_pkg::ST_BOX2:
            begin
                x_reg   <= xlo_reg[XW-1:0];
                y_reg   <= ylo_reg[YW-1:0];
                row_reg <= AW'(ylo_reg[YW-1:0]) * AW'(trz_pkg::SCREEN_WIDTH);
            end
            trz_pkg::ST_PD:
            begin
                dx_reg <= EW'(ax_reg) - EW'(x_reg);
                dy_reg <= EW'(ay_reg) - EW'(y_reg);
            end
            trz_pkg::ST_M1: acc_reg <= prod_reg;
            trz_pkg::ST_M2: ux_reg  <= WW'(acc_reg - prod_reg);
            trz_pkg::ST_M3: acc_reg <= prod_reg;
            trz_pkg::ST_M4: uy_reg  <= WW'(acc_reg - prod_reg);
            trz_pkg::ST_PW:
            begin
                w1_reg <= w1_n;
                w2_reg <= w2_n;
                w0_reg <= $signed(WW'(area_abs_reg)) - w1_n - w2_n;
            end
            trz_pkg::ST_N1: acc_reg <= prod_reg;
            trz_pkg::ST_N2: acc_reg <= acc_reg + prod_reg;
            trz_pkg::ST_N3:
            begin
                // floor toward minus infinity: bias a negative magnitude up
                neg_reg <= num[PRW-1];
                dvd_reg <= num[PRW-1] ? QW'(num_mag) + QW'(area_abs_reg) - QW'(1)
                                      : QW'(num_mag);
            end
            trz_pkg::ST_SAT:
            begin
                if (neg_reg)
                begin
                    dq_reg <= (div_q > trz_pkg::DEPTH_MAG_NEG) ? trz_pkg::DEPTH_LOW
                                                               : DB'(QW'(0) - div_q);
                end
                else
                begin
                    dq_reg <= (div_q > trz_pkg::DEPTH_MAG_POS) ? trz_pkg::DEPTH_HIGH
                                                               : DB'(div_q);
                end
            end
            trz_pkg::ST_PCMP:
            begin
                if ($signed(dep_rdata) < dq_reg && cnt_reg != trz_pkg::COUNT_MAX)
                begin
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
            end
            trz_pkg::ST_PNEXT:
            begin
                // advance along the row, then drop to the next row
                if (AW'(x_reg) == AW'(xhi_reg))
                begin
                    x_reg   <= xlo_reg[XW-1:0];
                    y_reg   <= y_reg + YW'(1);
                    row_reg <= row_reg + AW'(trz_pkg::SCREEN_WIDTH);
                end
                else
                begin
                    x_reg <= x_reg + XW'(1);
                end
            end
            trz_pkg::ST_FINISH:
            begin
                // load the output register only once the previous result is gone
                if (out_free)
                begin
                    res_color_reg <= rcol_reg;
                    res_depth_reg <= rdep_reg;
                    res_count_reg <= (op_reg == trz_pkg::OP_DRAW) ? cnt_reg : '0;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_color   = res_color_reg;
    assign out_ch.pixel_depth   = res_depth_reg;
    assign out_ch.written_count = res_count_reg;

    // a depth write during the pixel walk only replaces a smaller stored depth
    a_depth_test: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trz_pkg::ST_PCMP && mem_we) |-> ($signed(dep_rdata) < dq_reg))
        else $error("depth write without a passing depth test");

    // the divider reports only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == trz_pkg::ST_DIVW))
        else $error("divider finished outside of its wait state");

    // a new result appears only out of the finish step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == trz_pkg::ST_FINISH))
        else $error("result raised outside of the finish step");

    // the clear sweep never overlaps an accepted request
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trz_pkg::ST_CLEAR) |-> !in_ch.ready)
        else $error("request channel open during the clear sweep");
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle rasterizer with depth buffer.
// A queue of requests feeds a bursty driver; a mirror of both stores predicts
// every result, and a monitor compares each result with the oldest prediction
// while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        trz_pkg::op_t       op;
        logic signed [11:0] ax, ay, bx, by, cx, cy;
        logic signed [15:0] az, bz, cz;
        logic [23:0]        col;
    } raster_req_t;

    typedef struct {
        logic [23:0]        col;
        logic signed [15:0] depth;
        logic [12:0]        count;
    } pixel_result_t;

    logic clk;
    logic rst_n;

    trz_in_if  in_ch ();
    trz_out_if out_ch ();

    triangle_raster_zbuffer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Mirror of the frame: one depth and one color per pixel.
    logic signed [15:0] depth_mirror [trz_pkg::PIXELS];
    logic [23:0]        color_mirror [trz_pkg::PIXELS];

    raster_req_t   pending_reqs [$];
    pixel_result_t expected_pixels [$];

    int  accepted_reqs;
    int  error_count;
    int  cycle_count;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void wipe_frame();
        for (int i = 0; i < trz_pkg::PIXELS; i++)
        begin
            depth_mirror[i] = trz_pkg::DEPTH_LOW;
            color_mirror[i] = '0;
        end
    endfunction

    // Walk the clamped box, test the edge weights, interpolate with floor
    // division and update the mirror where the new depth is strictly nearer.
    function automatic logic [12:0] raster_draw(raster_req_t r);
        longint ex1, ey1, ex2, ey2, area, sgn, x0, x1, y0, y1;
        longint dx, dy, ux, uy, w0, w1, w2, num, q, idx;
        logic [12:0] count;
        ex1 = longint'(r.cx) - r.ax;
        ey1 = longint'(r.cy) - r.ay;
        ex2 = longint'(r.bx) - r.ax;
        ey2 = longint'(r.by) - r.ay;
        area = ex1 * ey2 - ex2 * ey1;
        sgn = 1;
        count = '0;
        if (area == 0)
            return '0;
        if (area < 0)
        begin
            sgn = -1;
            area = -area;
        end
        x0 = r.ax; if (r.bx < x0) x0 = r.bx; if (r.cx < x0) x0 = r.cx;
        y0 = r.ay; if (r.by < y0) y0 = r.by; if (r.cy < y0) y0 = r.cy;
        x1 = r.ax; if (r.bx > x1) x1 = r.bx; if (r.cx > x1) x1 = r.cx;
        y1 = r.ay; if (r.by > y1) y1 = r.by; if (r.cy > y1) y1 = r.cy;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > trz_pkg::SCREEN_WIDTH - 1) x1 = trz_pkg::SCREEN_WIDTH - 1;
        if (y1 > trz_pkg::SCREEN_HEIGHT - 1) y1 = trz_pkg::SCREEN_HEIGHT - 1;
        for (longint x = x0; x <= x1; x++)
        begin
            for (longint y = y0; y <= y1; y++)
            begin
                dx = r.ax - x;
                dy = r.ay - y;
                ux = ex2 * dy - dx * ey2;
                uy = dx * ey1 - ex1 * dy;
                w0 = (area * sgn - ux - uy) * sgn;
                w1 = uy * sgn;
                w2 = ux * sgn;
                if (w0 < 0 || w1 < 0 || w2 < 0)
                    continue;
                num = w0 * r.az + w1 * r.bz + w2 * r.cz;
                q = num / area;
                if (num % area != 0 && num < 0)
                    q--;
                if (q < -32768) q = -32768;
                if (q > 32767) q = 32767;
                idx = x + y * trz_pkg::SCREEN_WIDTH;
                if (depth_mirror[idx] < q)
                begin
                    depth_mirror[idx] = q[15:0];
                    color_mirror[idx] = r.col;
                    if (count != trz_pkg::COUNT_MAX)
                        count++;
                end
            end
        end
        return count;
    endfunction

    function automatic pixel_result_t predict_pixel(raster_req_t r);
        pixel_result_t res;
        int idx;
        res = '{default: '0};
        case (r.op)
            trz_pkg::OP_CLEAR: wipe_frame();
            trz_pkg::OP_DRAW:  res.count = raster_draw(r);
            trz_pkg::OP_READ:
            begin
                if (r.ax >= 0 && r.ax < trz_pkg::SCREEN_WIDTH && r.ay >= 0
                    && r.ay < trz_pkg::SCREEN_HEIGHT)
                begin
                    idx = int'(r.ax) + int'(r.ay) * trz_pkg::SCREEN_WIDTH;
                    res.col = color_mirror[idx];
                    res.depth = depth_mirror[idx];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;
    raster_req_t held_req;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            // Predict the request the block takes on this edge.
            if (in_ch.valid)
            begin
                expected_pixels.push_back(predict_pixel(held_req));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (gap_left > 0)
            begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                held_req = pending_reqs.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.opcode     <= held_req.op;
                in_ch.ax         <= held_req.ax;
                in_ch.ay         <= held_req.ay;
                in_ch.az         <= held_req.az;
                in_ch.bx         <= held_req.bx;
                in_ch.by         <= held_req.by;
                in_ch.bz         <= held_req.bz;
                in_ch.cx         <= held_req.cx;
                in_ch.cy         <= held_req.cy;
                in_ch.cz         <= held_req.cz;
                in_ch.fill_color <= held_req.col;
                if (burst_left <= 1)
                begin
                    // Close the burst; half the time with no gap at all.
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 1) == 1) ? $urandom_range(1, 12) : 0;
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern with a single long hold-off
    // ------------------------------------------------------------------------
    int  stall_mode;
    int  mode_left;
    int  hold_left;
    bit  hold_done;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
            mode_left    <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            // Hold off long enough for the block to fill and refuse requests.
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && accepted_reqs >= 40)
        begin
            hold_done    <= 1'b1;
            hold_left    <= 3000;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(50, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 9) > 2);
                default: out_ch.ready <= (cycle_count[3:0] < 5);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_result_t exp_px;
        int errs;
        errs = 0;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t unexpected result color %h depth %h count %0d", $realtime,
                         out_ch.pixel_color, out_ch.pixel_depth, out_ch.written_count);
                errs++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (out_ch.pixel_color !== exp_px.col)
                begin
                    $display("%0t pixel_color expected %h actual %h", $realtime,
                             exp_px.col, out_ch.pixel_color);
                    errs++;
                end
                if (out_ch.pixel_depth !== exp_px.depth)
                begin
                    $display("%0t pixel_depth expected %h actual %h", $realtime,
                             exp_px.depth, out_ch.pixel_depth);
                    errs++;
                end
                if (out_ch.written_count !== exp_px.count)
                begin
                    $display("%0t written_count expected %0d actual %0d", $realtime,
                             exp_px.count, out_ch.written_count);
                    errs++;
                end
            end
            if (errs != 0)
                error_count <= error_count + errs;
        end
    end

    // Timeout: generous bound on the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic raster_req_t make_req(trz_pkg::op_t op, int ax, int ay, int az,
                                            int bx, int by, int bz, int cx, int cy,
                                            int cz, int col);
        raster_req_t r;
        r.op = op;
        r.ax = 12'(ax); r.ay = 12'(ay); r.az = 16'(az);
        r.bx = 12'(bx); r.by = 12'(by); r.bz = 16'(bz);
        r.cx = 12'(cx); r.cy = 12'(cy); r.cz = 16'(cz);
        r.col = 24'(col);
        return r;
    endfunction

    function automatic int rand_depth();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 7) * 100 - 300;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Small triangle around a random screen point, often straddling an edge.
    function automatic raster_req_t small_draw();
        int px, py;
        px = $urandom_range(0, 63);
        py = $urandom_range(0, 63);
        return make_req(trz_pkg::OP_DRAW,
            px + int'($urandom_range(0, 8)) - 4, py + int'($urandom_range(0, 8)) - 4,
            rand_depth(),
            px + int'($urandom_range(0, 8)) - 4, py + int'($urandom_range(0, 8)) - 4,
            rand_depth(),
            px + int'($urandom_range(0, 8)) - 4, py + int'($urandom_range(0, 8)) - 4,
            rand_depth(), $urandom_range(0, 24'hFFFFFF));
    endfunction

    // Wide coordinates, all on one side of the screen so the box clamps empty.
    function automatic raster_req_t far_draw();
        int v [6];
        bit neg_x;
        neg_x = $urandom_range(0, 1);
        for (int i = 0; i < 6; i++)
            v[i] = int'($urandom_range(0, 4095)) - 2048;
        for (int i = 0; i < 6; i += 2)
            v[i] = neg_x ? -int'($urandom_range(1, 2048)) : int'($urandom_range(64, 2047));
        return make_req(trz_pkg::OP_DRAW, v[0], v[1], rand_depth(), v[2], v[3], rand_depth(),
                        v[4], v[5], rand_depth(), $urandom_range(0, 24'hFFFFFF));
    endfunction

    initial
    begin
        int pick;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = trz_pkg::OP_NOP;
        in_ch.ax         = '0;
        in_ch.ay         = '0;
        in_ch.az         = '0;
        in_ch.bx         = '0;
        in_ch.by         = '0;
        in_ch.bz         = '0;
        in_ch.cx         = '0;
        in_ch.cy         = '0;
        in_ch.cz         = '0;
        in_ch.fill_color = '0;
        out_ch.ready     = 1'b0;
        accepted_reqs    = 0;
        error_count      = 0;
        cycle_count      = 0;
        wipe_frame();

        // Directed part: fresh frame, ties, degenerate and clamped boxes.
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0));
        // equal to the cleared depth: nothing written
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 2, 2, -32768, 6, 2, -32768, 2, 6,
                                        -32768, 24'hFFFFFF));
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 2, 2, 100, 6, 2, 100, 2, 6, 100,
                                        24'h123456));
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 2, 2, 100, 6, 2, 100, 2, 6, 100,
                                        24'hABCDEF));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        // clockwise winding, depth extremes
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 10, 10, 32767, 10, 15, -32768, 15,
                                        10, 0, 24'h00FF00));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 11, 11, 0, 0, 0, 0, 0, 0, 0, 0));
        // collinear: zero area
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 1, 1, 500, 5, 5, 500, 9, 9, 500,
                                        24'hFF0000));
        // boxes entirely off screen
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, -2048, -2048, 7, -2000, -1, 7, -1,
                                        -2048, 7, 24'h0000FF));
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 2047, 2047, 7, 100, 2047, 7, 2047,
                                        64, 7, 24'h0000FF));
        // box clamped at the far corner
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 60, 60, 32767, 2047, 60, 32767, 60,
                                        2047, 32767, 24'h808080));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0));
        // reads off screen
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 64, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 2047, -2048, 0, 0, 0, 0, 0, 0, 0,
                                        0));
        pending_reqs.push_back(make_req(trz_pkg::OP_NOP, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                                        24'hFFFFFF));
        // one large triangle over half the screen
        pending_reqs.push_back(make_req(trz_pkg::OP_DRAW, 0, 0, -20000, 63, 0, 20000, 0, 63,
                                        5, 24'h5A5A5A));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 20, 20, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(trz_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(trz_pkg::OP_READ, 20, 20, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random part: mostly small draws and reads of random screen pixels.
        for (int n = 0; n < 120; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                pending_reqs.push_back(small_draw());
            else if (pick < 46)
                pending_reqs.push_back(far_draw());
            else if (pick < 84)
                pending_reqs.push_back(make_req(trz_pkg::OP_READ, $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 65535), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 65535), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 65535),
                    $urandom_range(0, 24'hFFFFFF)));
            else if (pick < 91)
                pending_reqs.push_back(make_req(trz_pkg::OP_READ,
                    int'($urandom_range(0, 4095)) - 2048,
                    int'($urandom_range(0, 4095)) - 2048, 0, 0, 0, 0, 0, 0, 0, 0));
            else if (pick < 97)
                pending_reqs.push_back(make_req(trz_pkg::OP_NOP, $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 65535), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 65535), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 65535),
                    $urandom_range(0, 24'hFFFFFF)));
            else
                pending_reqs.push_back(make_req(trz_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                                0));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request taken, every result checked, then a short tail.
        wait (pending_reqs.size() == 0 && !in_ch.valid);
        wait (expected_pixels.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/trz_pkg.sv
rtl/trz_in_if.sv
rtl/trz_out_if.sv
rtl/trz_ram.sv
rtl/trz_div.sv
rtl/triangle_raster_zbuffer.sv
test/tb.sv
